/* rtl/core/brp_pkg.sv */
// ============================================================================
// brp_pkg
// Shared types and constants of the buffer residency planner.
// ============================================================================
package brp_pkg;

	// Input index fields carried by every run beat.
	localparam int unsigned NUM_IN = 4;
	// Highest number of operation inputs that are taken into account.
	localparam int unsigned MAX_OP_INPUTS = 4;

	localparam logic [31:0] CAP_RESET = 32'd1048576;

	// Table word: {remaining uses, size, persistent, graph output}.
	localparam int unsigned TAB_W = 42;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_RUN  = 1'b1;

	typedef enum logic [1:0] {
		ERR_OK        = 2'd0,
		ERR_UNDERFLOW = 2'd1,
		ERR_OUT_RES   = 2'd2,
		ERR_ACCOUNT   = 2'd3
	} err_t;

	typedef struct packed {
		logic [7:0]  uses;
		logic [31:0] size;
		logic        pers;
		logic        ext;
	} tab_word_t;

endpackage

/* rtl/core/brp_ram.sv */
// ============================================================================
// brp_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module brp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/buffer_residency_planner.sv */
// ============================================================================
// buffer_residency_planner
// Tracks which tensors stay resident in an on-chip buffer and plans/commits
// residency for one operation at a time.
// ============================================================================
//
// Channel  Dir  Beat contents
// s_axis   in   tuser: operation; tdata: load and run fields (93 bits in 96)
// m_axis   out  tdata: one result per accepted beat (79 bits in 80)
// cfg      in   cfg_we/cfg_wdata: buffer capacity in bytes
//
// A load beat goes from acceptance straight to the final state, where its
// result is registered. A run beat first passes the read and walk states:
// the table and residency memories have one read port, so
// the five entries are fetched one per cycle, and each input is
// then walked once per phase (reclaim, pin planning, commit, pin commit,
// write-back), with one state each for the plan, the output and the check.
// The next beat can be accepted in the cycle in which the result is raised;
// no beat is taken while one is in progress.
// After reset a clearing pass zeroes every entry of the residency
// memory; no beat is accepted until it ends. A stalled result is held in the
// output register and the next beat waits in its final cycle.
module buffer_residency_planner #(
	parameter int unsigned TENSOR_SLOTS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata from bit 0: tensor_index(8), tensor_bytes(32), consumer_count(8),
	// is_persistent(1), is_graph_output(1), input_count(3), input_tensor_a(8),
	// input_tensor_b(8), input_tensor_c(8), input_tensor_d(8), output_tensor(8)
	input  logic [95:0] s_axis_tdata,
	// tuser: operation(1)
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata from bit 0: inputs_in_buffer(4), retain_input_mask(4),
	// keep_output(1), released_mask(4), occ_before(32),
	// occ_after(32), error_code(2)
	output logic [79:0] m_axis_tdata
);

	localparam int unsigned IW = $clog2(TENSOR_SLOTS);
	localparam int unsigned NI = brp_pkg::NUM_IN;
	localparam logic [2:0] NMAX = (brp_pkg::MAX_OP_INPUTS < NI) ?
		3'(brp_pkg::MAX_OP_INPUTS) : 3'(NI);

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_READ   = 4'd2;
	localparam logic [3:0] S_RECL   = 4'd3;
	localparam logic [3:0] S_PLAN   = 4'd4;
	localparam logic [3:0] S_PIN    = 4'd5;
	localparam logic [3:0] S_COMMIT = 4'd6;
	localparam logic [3:0] S_OUTP   = 4'd7;
	localparam logic [3:0] S_PINC   = 4'd8;
	localparam logic [3:0] S_CHECK  = 4'd9;
	localparam logic [3:0] S_WRITE  = 4'd10;
	localparam logic [3:0] S_DONE   = 4'd11;

	// Index fields wrap modulo the table depth through a constant table.
	logic [IW-1:0] slot_lut [256];
	for (genvar g = 0; g < 256; g++) begin : g_lut
		assign slot_lut[g] = IW'(g % TENSOR_SLOTS);
	end

	logic [3:0]  state_q;
	logic [2:0]  k_q;
	logic [IW-1:0] clr_q;
	logic [31:0] cap_q;
	logic [31:0] occ_q;
	logic [31:0] occ_start_q;

	logic [IW-1:0] idx_q [NI];
	logic [IW-1:0] outt_q;
	logic [2:0]    n_q;
	logic [7:0]    rem_q  [NI];
	logic [7:0]    remw_q [NI];
	logic [31:0]   sz_q   [NI];
	logic          pers_q [NI];
	logic          ext_q  [NI];
	logic [NI-1:0] res0_q;
	logic [NI-1:0] resw_q;
	logic          oext_q;
	logic [7:0]    ouses_q;
	logic [31:0]   osize_q;
	logic          ores_q;

	logic [34:0]   recl_q;
	logic [34:0]   plan_q;
	logic signed [36:0] occw_q;
	logic          rout_q;
	logic [NI-1:0] retin_q;
	logic [NI-1:0] rel_q;
	brp_pkg::err_t err_q;

	logic          out_valid_q;
	logic [79:0]   out_data_q;

	// Table and residency memories.
	logic          tab_we, res_we;
	logic [IW-1:0] tab_waddr, res_waddr, rd_addr;
	brp_pkg::tab_word_t tab_wdata, tab_rd;
	logic [brp_pkg::TAB_W-1:0] tab_rd_raw;
	logic          res_wdata, res_rd;

	brp_ram #(.WIDTH(brp_pkg::TAB_W), .DEPTH(TENSOR_SLOTS)) u_tab (
		.clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
		.raddr(rd_addr), .rdata(tab_rd_raw)
	);
	brp_ram #(.WIDTH(1), .DEPTH(TENSOR_SLOTS)) u_res (
		.clk(clk), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
		.raddr(rd_addr), .rdata(res_rd)
	);
	assign tab_rd = brp_pkg::tab_word_t'(tab_rd_raw);

	logic accept, out_take, out_load;
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;
	assign out_take = out_valid_q && m_axis_tready;
	// The result register takes a new beat once it is empty or being drained.
	assign out_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	// Input beat fields.
	logic [2:0] in_cnt, in_n;
	logic [7:0] in_idx [NI];
	assign in_cnt = s_axis_tdata[52:50];
	assign in_n = (in_cnt > NMAX) ? NMAX : in_cnt;
	assign in_idx[0] = s_axis_tdata[60:53];
	assign in_idx[1] = s_axis_tdata[68:61];
	assign in_idx[2] = s_axis_tdata[76:69];
	assign in_idx[3] = s_axis_tdata[84:77];

	// Pairwise index matches among the valid inputs.
	logic [NI-1:0] vld;
	logic [NI-1:0] same [NI];
	logic [2:0]    uses [NI];
	logic [NI-1:0] first;
	logic [NI-1:0] is_out;
	always_comb begin
		for (int i = 0; i < NI; i++) begin
			vld[i] = (3'(i) < n_q);
			is_out[i] = vld[i] && (idx_q[i] == outt_q);
		end
		for (int i = 0; i < NI; i++) begin
			uses[i] = '0;
			first[i] = 1'b1;
			for (int j = 0; j < NI; j++) begin
				same[i][j] = vld[j] && (idx_q[j] == idx_q[i]);
				if (same[i][j]) begin
					uses[i] = uses[i] + 3'd1;
					if (j < i) first[i] = 1'b0;
				end
			end
		end
	end

	// Room left against the running plan.
	logic [32:0] room;
	assign room = (plan_q >= {3'b0, cap_q}) ? 33'd0 : {1'b0, cap_q} - plan_q[32:0];

	logic [1:0] ki;
	assign ki = k_q[1:0];

	logic [NI-1:0] already;
	always_comb begin
		for (int i = 0; i < NI; i++) begin
			already[i] = 1'b0;
			for (int j = 0; j < i; j++) begin
				if (same[i][j] && retin_q[j]) already[i] = 1'b1;
			end
		end
	end

	logic out_res;
	always_comb begin
		out_res = ores_q;
		for (int i = 0; i < NI; i++) begin
			if (is_out[i]) out_res = resw_q[i];
		end
	end

	logic [7:0] rem_dec;
	assign rem_dec = remw_q[ki] - 8'd1;

	// Memory port control.
	always_comb begin
		tab_we = 1'b0;
		tab_waddr = idx_q[ki];
		tab_wdata = '{uses: remw_q[ki], size: sz_q[ki], pers: pers_q[ki], ext: ext_q[ki]};
		res_we = 1'b0;
		res_waddr = idx_q[ki];
		res_wdata = resw_q[ki];
		rd_addr = (k_q < 3'd4) ? idx_q[ki] : outt_q;
		unique case (state_q)
			S_CLEAR: begin
				res_we = 1'b1;
				res_waddr = clr_q;
				res_wdata = 1'b0;
			end
			S_IDLE: begin
				tab_we = accept && (s_axis_tuser == brp_pkg::OP_LOAD);
				tab_waddr = slot_lut[s_axis_tdata[7:0]];
				tab_wdata = '{uses: s_axis_tdata[47:40], size: s_axis_tdata[39:8],
					pers: s_axis_tdata[48], ext: s_axis_tdata[49]};
			end
			S_WRITE: begin
				if (err_q == brp_pkg::ERR_OK) begin
					if (k_q < 3'd4) begin
						tab_we = vld[ki];
						res_we = vld[ki];
					end else begin
						res_we = rout_q;
						res_waddr = outt_q;
						res_wdata = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			k_q <= '0;
			clr_q <= '0;
			cap_q <= brp_pkg::CAP_RESET;
			occ_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == IW'(TENSOR_SLOTS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						k_q <= '0;
						state_q <= (s_axis_tuser == brp_pkg::OP_LOAD) ? S_DONE : S_READ;
					end
				end
				S_READ: begin
					if (k_q == 3'd5) begin
						k_q <= '0;
						state_q <= S_RECL;
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				S_RECL, S_PIN, S_COMMIT, S_PINC: begin
					if (k_q == 3'd3) begin
						k_q <= '0;
						priority case (state_q)
							S_RECL:   state_q <= S_PLAN;
							S_PIN:    state_q <= S_COMMIT;
							S_COMMIT: state_q <= S_OUTP;
							default:  state_q <= S_CHECK;
						endcase
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				S_PLAN:  state_q <= S_PIN;
				S_OUTP:  state_q <= S_PINC;
				S_CHECK: state_q <= S_WRITE;
				S_WRITE: begin
					if (k_q == 3'd4) begin
						k_q <= '0;
						state_q <= S_DONE;
						if (err_q == brp_pkg::ERR_OK) occ_q <= occw_q[31:0];
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				S_DONE: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	// Working copies and result.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				n_q <= (s_axis_tuser == brp_pkg::OP_LOAD) ? 3'd0 : in_n;
				for (int i = 0; i < NI; i++) idx_q[i] <= slot_lut[in_idx[i]];
				outt_q <= slot_lut[s_axis_tdata[92:85]];
				occ_start_q <= occ_q;
				recl_q <= '0;
				retin_q <= '0;
				rel_q <= '0;
				rout_q <= 1'b0;
				res0_q <= '0;
				err_q <= brp_pkg::ERR_OK;
			end
			S_READ: begin
				if (k_q != 3'd0) begin
					if (k_q == 3'd5) begin
						ouses_q <= tab_rd.uses;
						osize_q <= tab_rd.size;
						oext_q <= tab_rd.ext;
						ores_q <= res_rd;
					end else begin
						rem_q[2'(k_q - 3'd1)] <= tab_rd.uses;
						remw_q[2'(k_q - 3'd1)] <= tab_rd.uses;
						sz_q[2'(k_q - 3'd1)] <= tab_rd.size;
						pers_q[2'(k_q - 3'd1)] <= tab_rd.pers;
						ext_q[2'(k_q - 3'd1)] <= tab_rd.ext;
						res0_q[2'(k_q - 3'd1)] <= res_rd && vld[2'(k_q - 3'd1)];
						resw_q[2'(k_q - 3'd1)] <= res_rd;
					end
				end
				occw_q <= 37'(occ_q);
			end
			S_RECL: begin
				if (vld[ki] && first[ki] && res0_q[ki] && rem_q[ki] <= 8'(uses[ki])) begin
					recl_q <= recl_q + 35'(sz_q[ki]);
				end
				if (k_q == 3'd3) begin
					plan_q <= 35'(occ_q);
				end
			end
			S_PLAN: begin
				if (recl_q < 35'(occ_q)) plan_q <= 35'(occ_q) - recl_q;
				else plan_q <= '0;
			end
			S_PIN: begin
				if (k_q == 3'd0) begin
					// Output retention is decided on the plan after reclaim.
					if (!oext_q && ouses_q != 8'd0 && {1'b0, osize_q} <= room) begin
						rout_q <= 1'b1;
						plan_q <= plan_q + 35'(osize_q);
					end
				end else begin
					if (vld[2'(k_q - 3'd1)] && !res0_q[2'(k_q - 3'd1)] &&
						!already[2'(k_q - 3'd1)] && !pers_q[2'(k_q - 3'd1)] &&
						rem_q[2'(k_q - 3'd1)] > 8'(uses[2'(k_q - 3'd1)]) &&
						{1'b0, sz_q[2'(k_q - 3'd1)]} <= room) begin
						retin_q[2'(k_q - 3'd1)] <= 1'b1;
						plan_q <= plan_q + 35'(sz_q[2'(k_q - 3'd1)]);
					end
				end
			end
			S_COMMIT: begin
				if (k_q == 3'd0) begin
					// Last input of the pin walk.
					if (vld[3] && !res0_q[3] && !already[3] && !pers_q[3] &&
						rem_q[3] > 8'(uses[3]) && {1'b0, sz_q[3]} <= room) begin
						retin_q[3] <= 1'b1;
						plan_q <= plan_q + 35'(sz_q[3]);
					end
				end
				if (err_q == brp_pkg::ERR_OK && vld[ki]) begin
					if (remw_q[ki] == 8'd0) begin
						err_q <= brp_pkg::ERR_UNDERFLOW;
					end else begin
						for (int j = 0; j < NI; j++) begin
							if (same[ki][j]) remw_q[j] <= rem_dec;
						end
						if (rem_dec == 8'd0 && resw_q[ki]) begin
							for (int j = 0; j < NI; j++) begin
								if (same[ki][j]) resw_q[j] <= 1'b0;
							end
							occw_q <= occw_q - 37'(sz_q[ki]);
							rel_q[ki] <= 1'b1;
						end
					end
				end
			end
			S_OUTP: begin
				if (err_q == brp_pkg::ERR_OK && rout_q) begin
					if (out_res) begin
						err_q <= brp_pkg::ERR_OUT_RES;
					end else begin
						for (int i = 0; i < NI; i++) begin
							if (is_out[i]) resw_q[i] <= 1'b1;
						end
						occw_q <= occw_q + 37'(osize_q);
					end
				end
			end
			S_PINC: begin
				if (err_q == brp_pkg::ERR_OK && vld[ki] && retin_q[ki] && !resw_q[ki]) begin
					for (int j = 0; j < NI; j++) begin
						if (same[ki][j]) resw_q[j] <= 1'b1;
					end
					occw_q <= occw_q + 37'(sz_q[ki]);
				end
			end
			S_CHECK: begin
				if (err_q == brp_pkg::ERR_OK && (occw_q < 0 ||
					occw_q > $signed(37'(cap_q)) || occw_q != $signed(37'(plan_q)))) begin
					err_q <= brp_pkg::ERR_ACCOUNT;
				end
			end
			S_DONE: begin
				if (out_load) begin
					out_data_q[3:0] <= res0_q;
					// Occupancy is captured at acceptance and after the write-back.
					out_data_q[44:13] <= occ_start_q;
					out_data_q[76:45] <= occ_q;
					out_data_q[78:77] <= err_q;
					out_data_q[79] <= 1'b0;
					if (err_q == brp_pkg::ERR_OK) begin
						out_data_q[7:4] <= retin_q;
						out_data_q[8] <= rout_q;
						out_data_q[12:9] <= rel_q;
					end else begin
						out_data_q[7:4] <= '0;
						out_data_q[8] <= 1'b0;
						out_data_q[12:9] <= '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !s_axis_tready)
		else $error("beat accepted during clearing pass");

	assert property (@(posedge clk) disable iff (!arst_n)
		(res_we && state_q != S_CLEAR) |-> (err_q == brp_pkg::ERR_OK))
		else $error("residency written back after an error");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> ($past(state_q) == S_DONE))
		else $error("result raised outside the final cycle");

endmodule

/* tb/buffer_residency_planner_tb.sv */
// ----------------------------------------------------------------------------
// buffer_residency_planner_tb
// Drives load and run beats into the residency planner, predicts every result
// with a behavioral copy of the tensor table and buffer occupancy, and checks
// each result field by field across several capacities and handshake phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module buffer_residency_planner_tb;

	typedef struct packed {
		logic [2:0]  pad;
		logic [7:0]  out_t;
		logic [7:0]  in_d;
		logic [7:0]  in_c;
		logic [7:0]  in_b;
		logic [7:0]  in_a;
		logic [2:0]  in_cnt;
		logic        ext;
		logic        pers;
		logic [7:0]  consumers;
		logic [31:0] nbytes;
		logic [7:0]  tidx;
	} op_word_t;

	typedef struct packed {
		logic        pad;
		logic [1:0]  err;
		logic [31:0] occ_after;
		logic [31:0] occ_before;
		logic [3:0]  released;
		logic        keep_out;
		logic [3:0]  pinned;
		logic [3:0]  in_buf;
	} plan_word_t;

	typedef struct {
		logic     kind;
		op_word_t word;
	} beat_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [79:0] m_axis_tdata;

	buffer_residency_planner DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// Predictor state.
	logic [7:0]  uses_left [256];
	logic [31:0] size_tab  [256];
	bit          pers_tab  [256];
	bit          ext_tab   [256];
	bit          resident  [256];
	logic [31:0] occupied;
	logic [31:0] capacity;

	beat_t      pending_beats[$];
	plan_word_t expected_plans[$];
	bit         loaded[256];
	int         errors;
	int         cycles;
	int         idle_pct;
	int         stall_pct;
	bit         in_taken;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint room_left(longint cap, longint planned);
		longint p;
		p = planned < 0 ? 0 : planned;
		return p >= cap ? 0 : cap - p;
	endfunction

	task automatic plan_op(input logic kind, input op_word_t w, output plan_word_t r);
		int n, i, j;
		logic [7:0] ix[4];
		int cnt[4];
		bit first[4];
		logic [7:0] rem[4];
		bit res[4];
		bit keep_out, out_res, already;
		logic [3:0] inbuf, pin, rel;
		brp_pkg::err_t err;
		longint cap, planned, occ, reclaim;
		logic [7:0] o;
		r = '0;
		r.occ_before = occupied;
		r.occ_after = occupied;
		if (kind == brp_pkg::OP_LOAD) begin
			size_tab[w.tidx] = w.nbytes;
			uses_left[w.tidx] = w.consumers;
			pers_tab[w.tidx] = w.pers;
			ext_tab[w.tidx] = w.ext;
			return;
		end
		cap = longint'({32'd0, capacity});
		n = w.in_cnt > 4 ? 4 : w.in_cnt;
		ix[0] = w.in_a; ix[1] = w.in_b; ix[2] = w.in_c; ix[3] = w.in_d;
		o = w.out_t;
		inbuf = '0; pin = '0; rel = '0; err = brp_pkg::ERR_OK;
		for (i = 0; i < n; i++) begin
			if (resident[ix[i]]) inbuf[i] = 1'b1;
			first[i] = 1; cnt[i] = 0;
			for (j = 0; j < n; j++)
				if (ix[j] == ix[i]) begin
					cnt[i]++;
					if (j < i) first[i] = 0;
				end
		end
		reclaim = 0;
		for (i = 0; i < n; i++)
			if (first[i] && resident[ix[i]] && uses_left[ix[i]] <= cnt[i])
				reclaim += longint'({32'd0, size_tab[ix[i]]});
		occ = longint'({32'd0, occupied});
		planned = occ - (reclaim < occ ? reclaim : occ);
		keep_out = !ext_tab[o] && uses_left[o] > 0 &&
			longint'({32'd0, size_tab[o]}) <= room_left(cap, planned);
		if (keep_out) planned += longint'({32'd0, size_tab[o]});
		for (i = 0; i < n; i++) begin
			if (inbuf[i]) continue;
			already = 0;
			for (j = 0; j < i; j++)
				if (ix[j] == ix[i] && pin[j]) already = 1;
			if (already || pers_tab[ix[i]]) continue;
			if (uses_left[ix[i]] > cnt[i] &&
					longint'({32'd0, size_tab[ix[i]]}) <= room_left(cap, planned)) begin
				pin[i] = 1'b1;
				planned += longint'({32'd0, size_tab[ix[i]]});
			end
		end
		// Commit on working copies; the tables change only when no error occurs.
		for (i = 0; i < n; i++) begin
			rem[i] = uses_left[ix[i]];
			res[i] = resident[ix[i]];
		end
		for (i = 0; i < n; i++) begin
			if (rem[i] == 0) begin
				err = brp_pkg::ERR_UNDERFLOW;
				break;
			end
			for (j = 0; j < n; j++)
				if (ix[j] == ix[i] && j != i) rem[j] = rem[i] - 8'd1;
			rem[i] = rem[i] - 8'd1;
			if (rem[i] == 0 && res[i]) begin
				for (j = 0; j < n; j++)
					if (ix[j] == ix[i]) res[j] = 0;
				occ -= longint'({32'd0, size_tab[ix[i]]});
				rel[i] = 1'b1;
			end
		end
		if (err == brp_pkg::ERR_OK && keep_out) begin
			out_res = resident[o];
			for (i = 0; i < n; i++)
				if (ix[i] == o) out_res = res[i];
			if (out_res) err = brp_pkg::ERR_OUT_RES;
			else begin
				for (i = 0; i < n; i++)
					if (ix[i] == o) res[i] = 1;
				occ += longint'({32'd0, size_tab[o]});
			end
		end
		if (err == brp_pkg::ERR_OK) begin
			for (i = 0; i < n; i++) begin
				if (!pin[i] || res[i]) continue;
				for (j = 0; j < n; j++)
					if (ix[j] == ix[i]) res[j] = 1;
				occ += longint'({32'd0, size_tab[ix[i]]});
			end
			if (occ < 0 || occ > cap || occ != planned) err = brp_pkg::ERR_ACCOUNT;
		end
		if (err == brp_pkg::ERR_OK) begin
			for (i = 0; i < n; i++) begin
				uses_left[ix[i]] = rem[i];
				resident[ix[i]] = res[i];
			end
			if (keep_out) resident[o] = 1;
			occupied = occ[31:0];
			r.pinned = pin;
			r.keep_out = keep_out;
			r.released = rel;
			r.occ_after = occupied;
		end
		r.in_buf = inbuf;
		r.err = err;
	endtask

	// Monitor: predicts on accepted input beats and checks accepted results.
	always @(posedge clk) begin
		plan_word_t exp_r, got;
		if (arst_n) begin
			if (cfg_we) capacity <= cfg_wdata;
			if (s_axis_tvalid && s_axis_tready) begin
				plan_op(s_axis_tuser, op_word_t'(s_axis_tdata), exp_r);
				expected_plans = {expected_plans, exp_r};
				in_taken = 1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = plan_word_t'(m_axis_tdata);
				if (expected_plans.size() == 0) begin
					$error("result beat with no expectation pending");
					errors++;
				end else begin
					exp_r = expected_plans.pop_front();
					if (got.in_buf !== exp_r.in_buf) begin
						$error("inputs_in_buffer exp %h got %h", exp_r.in_buf, got.in_buf);
						errors++;
					end
					if (got.pinned !== exp_r.pinned) begin
						$error("retain_input_mask exp %h got %h", exp_r.pinned, got.pinned);
						errors++;
					end
					if (got.keep_out !== exp_r.keep_out) begin
						$error("keep_output exp %h got %h", exp_r.keep_out, got.keep_out);
						errors++;
					end
					if (got.released !== exp_r.released) begin
						$error("released_mask exp %h got %h", exp_r.released, got.released);
						errors++;
					end
					if (got.occ_before !== exp_r.occ_before) begin
						$error("occ_before exp %h got %h", exp_r.occ_before,
							got.occ_before);
						errors++;
					end
					if (got.occ_after !== exp_r.occ_after) begin
						$error("occ_after exp %h got %h", exp_r.occ_after,
							got.occ_after);
						errors++;
					end
					if (got.err !== exp_r.err) begin
						$error("error_code exp %h got %h", exp_r.err, got.err);
						errors++;
					end
				end
			end
		end
	end

	// Driver and receiver stall, both changing on the falling edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || in_taken) begin
				in_taken = 0;
				if (pending_beats.size() > 0 && $urandom_range(99) >= idle_pct) begin
					s_axis_tuser <= pending_beats[0].kind;
					s_axis_tdata <= pending_beats[0].word;
					void'(pending_beats.pop_front());
					s_axis_tvalid <= 1'b1;
				end else
					s_axis_tvalid <= 1'b0;
			end
			m_axis_tready <= $urandom_range(99) >= stall_pct;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 600000) begin
			$display("buffer_residency_planner_tb: done, errors");
			$finish;
		end
	end

	function automatic logic [7:0] pick_loaded();
		logic [7:0] t;
		t = $urandom_range(99) < 85 ? 8'($urandom_range(15)) : 8'($urandom);
		while (!loaded[t]) t = 8'($urandom_range(15));
		return t;
	endfunction

	task automatic add_load(input logic [7:0] t, input logic [31:0] nb, input logic [7:0] c,
			input bit p, input bit e);
		beat_t b;
		b.kind = brp_pkg::OP_LOAD;
		b.word = op_word_t'({$urandom, $urandom, $urandom});
		b.word.pad = '0;
		b.word.tidx = t; b.word.nbytes = nb; b.word.consumers = c;
		b.word.pers = p; b.word.ext = e;
		loaded[t] = 1;
		pending_beats = {pending_beats, b};
	endtask

	task automatic add_run(input logic [2:0] n, input logic [7:0] a, input logic [7:0] b2,
			input logic [7:0] c, input logic [7:0] d, input logic [7:0] o);
		beat_t b;
		b.kind = brp_pkg::OP_RUN;
		b.word = op_word_t'({$urandom, $urandom, $urandom});
		b.word.pad = '0;
		b.word.in_cnt = n; b.word.out_t = o;
		b.word.in_a = a; b.word.in_b = b2; b.word.in_c = c; b.word.in_d = d;
		pending_beats = {pending_beats, b};
	endtask

	task automatic random_beat();
		logic [7:0] s[5];
		int n, k;
		logic [31:0] nb;
		if ($urandom_range(99) < 25) begin
			nb = $urandom_range(9) == 0 ? $urandom : $urandom_range(1500);
			add_load($urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(15)), nb,
				$urandom_range(19) == 0 ? 8'($urandom) : 8'($urandom_range(6)),
				$urandom_range(4) == 0, $urandom_range(5) == 0);
		end else begin
			n = $urandom_range(9) == 0 ? $urandom_range(7) : $urandom_range(1, 4);
			for (k = 0; k < 5; k++) s[k] = 8'($urandom);
			for (k = 0; k < (n > 4 ? 4 : n); k++) s[k] = pick_loaded();
			s[4] = pick_loaded();
			add_run(3'(n), s[0], s[1], s[2], s[3], s[4]);
		end
	endtask

	task automatic drain();
		while (pending_beats.size() > 0 || s_axis_tvalid || expected_plans.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		logic [31:0] caps[6];
		int ph, k;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = brp_pkg::OP_LOAD;
		m_axis_tready = 1'b0;
		occupied = '0;
		capacity = brp_pkg::CAP_RESET;
		errors = 0;
		cycles = 0;
		idle_pct = 0;
		stall_pct = 0;
		in_taken = 0;
		foreach (resident[t]) resident[t] = 0;
		caps[0] = brp_pkg::CAP_RESET; caps[1] = 32'd4096; caps[2] = 32'd0;
		caps[3] = 32'hFFFF_FFFF; caps[4] = 32'd1000; caps[5] = $urandom_range(600, 8000);
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: table extremes, saturation, repeats, underflow, output conflicts.
		for (k = 0; k < 16; k++)
			add_load(8'(k), 32'(100 * (k + 1)), 8'(k % 5 + 1), k == 3, k == 5);
		add_load(8'd255, 32'hFFFF_FFFF, 8'd255, 1'b1, 1'b1);
		add_load(8'd254, 32'd0, 8'd0, 1'b0, 1'b0);
		add_run(3'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd1);
		add_run(3'd7, 8'd2, 8'd2, 8'd4, 8'd6, 8'd7);
		add_run(3'd2, 8'd1, 8'd1, 8'd0, 8'd0, 8'd1);
		add_run(3'd1, 8'd254, 8'd0, 8'd0, 8'd0, 8'd8);
		add_run(3'd4, 8'd255, 8'd3, 8'd5, 8'd9, 8'd255);
		add_run(3'd3, 8'd7, 8'd8, 8'd1, 8'd0, 8'd7);

		for (ph = 0; ph < 6; ph++) begin
			if (ph > 0) begin
				drain();
				@(negedge clk);
				cfg_we <= 1'b1;
				cfg_wdata <= caps[ph];
				@(negedge clk);
				cfg_we <= 1'b0;
			end
			case (ph % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 46; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 46; end
				default: begin idle_pct = 24; stall_pct = 24; end
			endcase
			for (k = 0; k < 172; k++) random_beat();
		end
		drain();
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("buffer_residency_planner_tb: done, clean");
		else
			$display("buffer_residency_planner_tb: done, errors");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/brp_pkg.sv
rtl/core/brp_ram.sv
rtl/core/buffer_residency_planner.sv
tb/buffer_residency_planner_tb.sv
